FILE: sv/rmaa_pkg.sv
package rmaa_pkg;

   localparam int TRACE_ONE    = 16384;
   localparam int ROOT_FLOOR   = 1638;
   localparam int HALF_PI_Q16  = 102944;
   localparam int CORDIC_STEPS = 16;

   // pipelined unit sizes
   localparam int SQ1_W  = 16;   // root of a trace sum
   localparam int DIV1_N = 31;
   localparam int DIV1_D = 17;
   localparam int DIV1_Q = 20;   // quaternion magnitude
   localparam int SQ2_W  = 21;   // vector norm
   localparam int DIV2_N = 37;
   localparam int DIV2_D = 21;
   localparam int DIV2_Q = 17;   // scaled axis component

   // eleven single register stages plus the iterative units
   localparam int PIPE_LAT = 11 + SQ1_W + DIV1_Q + SQ2_W + CORDIC_STEPS + DIV2_Q;

   typedef struct packed {
      logic [3:0][16:0] tc;   // clamped trace sums
      logic [5:0][17:0] pr;   // off-diagonal sums and differences
   } mat_type;

   typedef struct packed {
      logic [20:0]      n;
      logic [2:0][20:0] v;
      logic             wneg;
   } cside_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } oside_type;

   function automatic logic [15:0] atan_q16(input logic [3:0] i);
      logic [15:0] a;
      case (i)
         4'd0:    a = 16'd51472;
         4'd1:    a = 16'd30386;
         4'd2:    a = 16'd16055;
         4'd3:    a = 16'd8150;
         4'd4:    a = 16'd4091;
         4'd5:    a = 16'd2047;
         4'd6:    a = 16'd1024;
         4'd7:    a = 16'd512;
         4'd8:    a = 16'd256;
         4'd9:    a = 16'd128;
         4'd10:   a = 16'd64;
         4'd11:   a = 16'd32;
         4'd12:   a = 16'd16;
         4'd13:   a = 16'd8;
         4'd14:   a = 16'd4;
         4'd15:   a = 16'd2;
         default: a = 16'd0;
      endcase
      return a;
   endfunction

endpackage

FILE: sv/rmaa_if.sv
interface rmaa_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] m00;
   logic signed [15:0] m01;
   logic signed [15:0] m02;
   logic signed [15:0] m10;
   logic signed [15:0] m11;
   logic signed [15:0] m12;
   logic signed [15:0] m20;
   logic signed [15:0] m21;
   logic signed [15:0] m22;
   modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
   modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface rmaa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] axis_angle_x;
   logic signed [16:0] axis_angle_y;
   logic signed [16:0] axis_angle_z;
   logic               zero_rotation;
   modport source(output valid, axis_angle_x, axis_angle_y, axis_angle_z, zero_rotation,
                  input ready);
   modport sink(input valid, axis_angle_x, axis_angle_y, axis_angle_z, zero_rotation,
                output ready);
endinterface

FILE: sv/rmaa_sqrt.sv
module rmaa_sqrt import rmaa_pkg::*; #(
   parameter int RW = SQ1_W
) (
   input  logic          clock,
   input  logic          en,
   input  logic [2*RW-1:0] rad,
   output logic [RW-1:0] root
);
   localparam int AW = 2 * RW;

   logic [AW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];

   // one result bit per stage, remainder holds rad - root^2
   for (genvar s = 0; s < RW; s++) begin : g_step
      localparam int B = RW - 1 - s;
      logic [AW-1:0] rem_cur;
      logic [RW-1:0] root_cur;
      logic [AW-1:0] trial;
      logic [AW-1:0] rem_in;
      logic [RW-1:0] root_in;

      if (s == 0) begin : g_first
         assign rem_cur  = rad;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
      end

      // (root + 2^B)^2 - root^2, bits do not overlap
      assign trial = (AW'(root_cur) << (B + 1)) | (AW'(1) << (2 * B));

      always_comb begin
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            root_in = root_cur | (RW'(1) << B);
         end else begin
            rem_in  = rem_cur;
            root_in = root_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

FILE: sv/rmaa_div.sv
module rmaa_div import rmaa_pkg::*; #(
   parameter int NW = DIV1_N,
   parameter int DW = DIV1_D,
   parameter int QW = DIV1_Q
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);
   localparam int EW = DW + QW;

   logic [EW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   // restoring division, one quotient bit per stage, num < den * 2^QW
   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int B = QW - 1 - s;
      logic [EW-1:0] rem_cur;
      logic [DW-1:0] den_cur;
      logic [QW-1:0] quo_cur;
      logic [EW-1:0] trial;
      logic [EW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_cur = EW'(num);
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign den_cur = den_ff[s-1];
         assign quo_cur = quo_ff[s-1];
      end

      assign trial = EW'(den_cur) << B;

      always_comb begin
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            quo_in = quo_cur | (QW'(1) << B);
         end else begin
            rem_in = rem_cur;
            quo_in = quo_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_cur;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

FILE: sv/rotation_matrix_to_axis_angle.sv
// channel  dir  handshake      beat
// req_bus  in   valid/ready    m00..m22, signed Q1.14
// rsp_bus  out  valid/ready    axis_angle_x/y/z signed Q2.14, zero_rotation
//
// one matrix per cycle unless a result beat waits; pipe depth is set by the
// two root units, the two long dividers and the 16 cordic stages in series.
// synchronous reset clears the valid line only.
// the whole pipe holds while a result beat waits on rsp_bus; req_bus.ready
// is low only then, nothing is dropped or repeated.
module rotation_matrix_to_axis_angle import rmaa_pkg::*; (
   input logic       clock,
   input logic       reset,
   rmaa_req_if.sink   req_bus,
   rmaa_rsp_if.source rsp_bus
);

   function automatic logic signed [17:0] sx(input logic [15:0] v);
      return {{2{v[15]}}, v};
   endfunction

   logic                ce;
   logic [PIPE_LAT-1:0] vld_ff;

   assign ce            = !vld_ff[PIPE_LAT-1] || rsp_bus.ready;
   assign req_bus.ready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_bus.valid};
      end
   end

   // stage a: trace sums and off-diagonal terms
   logic signed [17:0] t_a [4];
   mat_type            a_in;
   mat_type            a_ff;

   always_comb begin
      t_a[0] = 18'sd16384 + sx(req_bus.m00) + sx(req_bus.m11) + sx(req_bus.m22);
      t_a[1] = 18'sd16384 + sx(req_bus.m00) - sx(req_bus.m11) - sx(req_bus.m22);
      t_a[2] = 18'sd16384 - sx(req_bus.m00) + sx(req_bus.m11) - sx(req_bus.m22);
      t_a[3] = 18'sd16384 - sx(req_bus.m00) - sx(req_bus.m11) + sx(req_bus.m22);
      for (int k = 0; k < 4; k++) begin
         a_in.tc[k] = t_a[k][17] ? 17'd0 : t_a[k][16:0];
      end
      a_in.pr[0] = sx(req_bus.m21) - sx(req_bus.m12);
      a_in.pr[1] = sx(req_bus.m02) - sx(req_bus.m20);
      a_in.pr[2] = sx(req_bus.m10) - sx(req_bus.m01);
      a_in.pr[3] = sx(req_bus.m10) + sx(req_bus.m01);
      a_in.pr[4] = sx(req_bus.m02) + sx(req_bus.m20);
      a_in.pr[5] = sx(req_bus.m12) + sx(req_bus.m21);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_ff <= a_in;
      end
   end

   // trace roots
   logic [SQ1_W-1:0] r_s [4];
   for (genvar k = 0; k < 4; k++) begin : g_sq1
      rmaa_sqrt #(.RW(SQ1_W)) u_sqrt (
         .clock (clock),
         .en    (ce),
         .rad   ({1'b0, a_ff.tc[k], 14'd0}),
         .root  (r_s[k])
      );
   end

   mat_type dly1_ff [SQ1_W];
   always_ff @(posedge clock) begin
      if (ce) begin
         dly1_ff[0] <= a_ff;
         for (int i = 1; i < SQ1_W; i++) begin
            dly1_ff[i] <= dly1_ff[i-1];
         end
      end
   end

   // stage b: pick the largest root, lowest index on ties
   mat_type          mb;
   logic [1:0]       sel_b;
   logic [SQ1_W-1:0] best_b;
   logic [3:0][17:0] row_b;
   logic [SQ1_W-1:0] b_root_ff;
   logic [3:0][17:0] b_row_ff;

   assign mb = dly1_ff[SQ1_W-1];

   always_comb begin
      sel_b  = 2'd0;
      best_b = r_s[0];
      for (int k = 1; k < 4; k++) begin
         if (r_s[k] > best_b) begin
            sel_b  = 2'(k);
            best_b = r_s[k];
         end
      end
      case (sel_b)
         2'd0: begin
            row_b[0] = {1'b0, mb.tc[0]};
            row_b[1] = mb.pr[0];
            row_b[2] = mb.pr[1];
            row_b[3] = mb.pr[2];
         end
         2'd1: begin
            row_b[0] = mb.pr[0];
            row_b[1] = {1'b0, mb.tc[1]};
            row_b[2] = mb.pr[3];
            row_b[3] = mb.pr[4];
         end
         2'd2: begin
            row_b[0] = mb.pr[1];
            row_b[1] = mb.pr[3];
            row_b[2] = {1'b0, mb.tc[2]};
            row_b[3] = mb.pr[5];
         end
         default: begin
            row_b[0] = mb.pr[2];
            row_b[1] = mb.pr[4];
            row_b[2] = mb.pr[5];
            row_b[3] = {1'b0, mb.tc[3]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         b_root_ff <= best_b;
         b_row_ff  <= row_b;
      end
   end

   // stage c: divider operands, rounding half of d folded into the dividend
   logic [SQ1_W-1:0]  rc_c;
   logic [DIV1_N-1:0] num_c [4];
   logic [3:0]        neg_c;
   logic [17:0]       mag_c [4];
   logic [DIV1_N-1:0] c_num_ff [4];
   logic [DIV1_D-1:0] c_den_ff;
   logic [3:0]        c_neg_ff;

   always_comb begin
      rc_c = (b_root_ff > SQ1_W'(ROOT_FLOOR)) ? b_root_ff : SQ1_W'(ROOT_FLOOR);
      for (int k = 0; k < 4; k++) begin
         neg_c[k] = b_row_ff[k][17];
         mag_c[k] = neg_c[k] ? (18'd0 - b_row_ff[k]) : b_row_ff[k];
         num_c[k] = {mag_c[k][16:0], 14'd0} + DIV1_N'(rc_c);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         c_num_ff <= num_c;
         c_den_ff <= {rc_c, 1'b0};
         c_neg_ff <= neg_c;
      end
   end

   logic [DIV1_Q-1:0] q_div [4];
   for (genvar k = 0; k < 4; k++) begin : g_div1
      rmaa_div #(.NW(DIV1_N), .DW(DIV1_D), .QW(DIV1_Q)) u_div (
         .clock (clock),
         .en    (ce),
         .num   (c_num_ff[k]),
         .den   (c_den_ff),
         .quo   (q_div[k])
      );
   end

   logic [3:0] neg_dly_ff [DIV1_Q];
   always_ff @(posedge clock) begin
      if (ce) begin
         neg_dly_ff[0] <= c_neg_ff;
         for (int i = 1; i < DIV1_Q; i++) begin
            neg_dly_ff[i] <= neg_dly_ff[i-1];
         end
      end
   end

   // stage d: signed quaternion
   logic [3:0][20:0] q_d;
   logic [3:0][20:0] d_q_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         q_d[k] = neg_dly_ff[DIV1_Q-1][k] ? (21'd0 - {1'b0, q_div[k]}) : {1'b0, q_div[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         d_q_ff <= q_d;
      end
   end

   // stage e: squares of the vector part
   logic signed [41:0] sq_e [3];
   logic [39:0]        e_sq_ff [3];
   logic [3:0][20:0]   e_q_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_e[k] = $signed(d_q_ff[k+1]) * $signed(d_q_ff[k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int k = 0; k < 3; k++) begin
            e_sq_ff[k] <= sq_e[k][39:0];
         end
         e_q_ff <= d_q_ff;
      end
   end

   // stage f: sum of squares
   logic [2*SQ2_W-1:0] f_sum_ff;
   logic [3:0][20:0]   f_q_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         f_sum_ff <= (2*SQ2_W)'(e_sq_ff[0]) + (2*SQ2_W)'(e_sq_ff[1])
                   + (2*SQ2_W)'(e_sq_ff[2]);
         f_q_ff   <= e_q_ff;
      end
   end

   logic [SQ2_W-1:0] n_s;
   rmaa_sqrt #(.RW(SQ2_W)) u_norm (
      .clock (clock),
      .en    (ce),
      .rad   (f_sum_ff),
      .root  (n_s)
   );

   logic [3:0][20:0] q_dly_ff [SQ2_W];
   always_ff @(posedge clock) begin
      if (ce) begin
         q_dly_ff[0] <= f_q_ff;
         for (int i = 1; i < SQ2_W; i++) begin
            q_dly_ff[i] <= q_dly_ff[i-1];
         end
      end
   end

   // stage g: cordic operands
   logic [3:0][20:0] qg;
   logic [20:0]      absw_g;
   logic [19:0]      g_absw_ff;
   cside_type        g_side_ff;

   assign qg     = q_dly_ff[SQ2_W-1];
   assign absw_g = qg[0][20] ? (21'd0 - qg[0]) : qg[0];

   always_ff @(posedge clock) begin
      if (ce) begin
         g_absw_ff      <= absw_g[19:0];
         g_side_ff.n    <= n_s;
         g_side_ff.v[0] <= qg[1];
         g_side_ff.v[1] <= qg[2];
         g_side_ff.v[2] <= qg[3];
         g_side_ff.wneg <= qg[0][20];
      end
   end

   // cordic vectoring, one rotation per stage
   logic signed [39:0] cx_ff [CORDIC_STEPS];
   logic signed [39:0] cy_ff [CORDIC_STEPS];
   logic signed [18:0] cz_ff [CORDIC_STEPS];
   cside_type          cs_ff [CORDIC_STEPS];

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
      logic signed [39:0] x_cur;
      logic signed [39:0] y_cur;
      logic signed [18:0] z_cur;
      cside_type          s_cur;
      logic signed [39:0] xs;
      logic signed [39:0] ys;
      logic signed [18:0] at;
      logic signed [39:0] x_in;
      logic signed [39:0] y_in;
      logic signed [18:0] z_in;

      if (s == 0) begin : g_first
         assign x_cur = $signed(40'({g_absw_ff, 16'd0}));
         assign y_cur = $signed(40'({g_side_ff.n, 16'd0}));
         assign z_cur = '0;
         assign s_cur = g_side_ff;
      end else begin : g_next
         assign x_cur = cx_ff[s-1];
         assign y_cur = cy_ff[s-1];
         assign z_cur = cz_ff[s-1];
         assign s_cur = cs_ff[s-1];
      end

      assign xs = x_cur >>> s;
      assign ys = y_cur >>> s;
      assign at = $signed({3'd0, atan_q16(4'(s))});

      always_comb begin
         if (y_cur > 40'sd0) begin
            x_in = x_cur + ys;
            y_in = y_cur - xs;
            z_in = z_cur + at;
         end else begin
            x_in = x_cur - ys;
            y_in = y_cur + xs;
            z_in = z_cur - at;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            cx_ff[s] <= x_in;
            cy_ff[s] <= y_in;
            cz_ff[s] <= z_in;
            cs_ff[s] <= s_cur;
         end
      end
   end

   // stage h: clamp and halve to the final angle
   logic signed [18:0] zl;
   logic [16:0]        zc_h;
   logic [17:0]        zr_h;
   logic [15:0]        h_ang_ff;
   cside_type          h_side_ff;

   assign zl = cz_ff[CORDIC_STEPS-1];

   always_comb begin
      if (zl < 19'sd0) begin
         zc_h = 17'd0;
      end else if (zl > 19'sd102944) begin
         zc_h = 17'(HALF_PI_Q16);
      end else begin
         zc_h = zl[16:0];
      end
      zr_h = {1'b0, zc_h} + 18'd1;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         h_ang_ff  <= zr_h[16:1];
         h_side_ff <= cs_ff[CORDIC_STEPS-1];
      end
   end

   // stage i: angle times vector part
   logic signed [37:0] prod_i [3];
   logic signed [37:0] i_prod_ff [3];
   logic [20:0]        i_n_ff;
   logic               i_wneg_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_i[k] = $signed({1'b0, h_ang_ff}) * $signed(h_side_ff.v[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         i_prod_ff <= prod_i;
         i_n_ff    <= h_side_ff.n;
         i_wneg_ff <= h_side_ff.wneg;
      end
   end

   // stage j: magnitudes plus half of n for rounding
   logic [37:0]       mag_j [3];
   logic [DIV2_N-1:0] num_j [3];
   oside_type         side_j;
   logic [DIV2_N-1:0] j_num_ff [3];
   logic [DIV2_D-1:0] j_n_ff;
   oside_type         j_side_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         side_j.neg[k] = i_prod_ff[k][37] ^ i_wneg_ff;
         mag_j[k] = i_prod_ff[k][37] ? (38'd0 - i_prod_ff[k]) : i_prod_ff[k];
         num_j[k] = DIV2_N'(mag_j[k][35:0]) + DIV2_N'(i_n_ff[20:1]);
      end
      side_j.zero = (i_n_ff == 21'd0);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         j_num_ff  <= num_j;
         j_n_ff    <= i_n_ff;
         j_side_ff <= side_j;
      end
   end

   logic [DIV2_Q-1:0] v_div [3];
   for (genvar k = 0; k < 3; k++) begin : g_div2
      rmaa_div #(.NW(DIV2_N), .DW(DIV2_D), .QW(DIV2_Q)) u_div (
         .clock (clock),
         .en    (ce),
         .num   (j_num_ff[k]),
         .den   (j_n_ff),
         .quo   (v_div[k])
      );
   end

   oside_type os_dly_ff [DIV2_Q];
   always_ff @(posedge clock) begin
      if (ce) begin
         os_dly_ff[0] <= j_side_ff;
         for (int i = 1; i < DIV2_Q; i++) begin
            os_dly_ff[i] <= os_dly_ff[i-1];
         end
      end
   end

   // stage k: output register
   oside_type   ok;
   logic [16:0] out_k [3];
   logic [16:0] k_out_ff [3];
   logic        k_zero_ff;

   assign ok = os_dly_ff[DIV2_Q-1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (ok.zero) begin
            out_k[k] = 17'd0;
         end else if (ok.neg[k]) begin
            out_k[k] = 17'd0 - v_div[k];
         end else begin
            out_k[k] = v_div[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         k_out_ff  <= out_k;
         k_zero_ff <= ok.zero;
      end
   end

   assign rsp_bus.valid         = vld_ff[PIPE_LAT-1];
   assign rsp_bus.axis_angle_x  = $signed(k_out_ff[0]);
   assign rsp_bus.axis_angle_y  = $signed(k_out_ff[1]);
   assign rsp_bus.axis_angle_z  = $signed(k_out_ff[2]);
   assign rsp_bus.zero_rotation = k_zero_ff;

endmodule

FILE: test/rotation_matrix_to_axis_angle_check.sv
`timescale 1ns / 100ps
module rotation_matrix_to_axis_angle_check (
   input  logic       clock,
   input  logic       reset,
   rmaa_req_if        req_bus,
   rmaa_rsp_if        rsp_bus,
   output int         fail_count,
   output int         pending
);

   typedef struct {
      logic signed [16:0] ax;
      logic signed [16:0] ay;
      logic signed [16:0] az;
      logic               zero;
   } axis_angle_type;

   axis_angle_type expected_vectors[$];

   localparam longint ATAN_TABLE[16] = '{51472, 30386, 16055, 8150, 4091, 2047,
                                         1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

   function automatic longint int_sqrt(longint v);
      longint root, bit_val;
      root = 0;
      bit_val = 64'sh1 << 62;
      while (bit_val > v) bit_val = bit_val >>> 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v = v - (root + bit_val);
            root = (root >>> 1) + bit_val;
         end else begin
            root = root >>> 1;
         end
         bit_val = bit_val >>> 2;
      end
      return root;
   endfunction

   // round to nearest, halves away from zero
   function automatic longint round_div(longint num, longint den);
      longint mag_q;
      mag_q = ((num < 0 ? -num : num) + den / 2) / den;
      return num < 0 ? -mag_q : mag_q;
   endfunction

   // twice atan2(y, x) via vectoring cordic, q14 result
   function automatic longint double_angle(longint y_in, longint x_in);
      longint x, y, z, xs, ys;
      x = x_in <<< 16;
      y = y_in <<< 16;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN_TABLE[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TABLE[i];
         end
      end
      if (z < 0) z = 0;
      if (z > rmaa_pkg::HALF_PI_Q16) z = rmaa_pkg::HALF_PI_Q16;
      return (z + 1) >>> 1;
   endfunction

   function automatic axis_angle_type matrix_to_axis_angle(longint m[9]);
      longint trace[4], root[4], row[4], quat[4], div, norm, angle, v;
      int pick;
      axis_angle_type res;
      trace[0] = rmaa_pkg::TRACE_ONE + m[0] + m[4] + m[8];
      trace[1] = rmaa_pkg::TRACE_ONE + m[0] - m[4] - m[8];
      trace[2] = rmaa_pkg::TRACE_ONE - m[0] + m[4] - m[8];
      trace[3] = rmaa_pkg::TRACE_ONE - m[0] - m[4] + m[8];
      pick = 0;
      for (int k = 0; k < 4; k++) begin
         if (trace[k] < 0) trace[k] = 0;
         root[k] = int_sqrt(trace[k] <<< 14);
         if (root[k] > root[pick]) pick = k;
      end
      case (pick)
         0: row = '{trace[0], m[7] - m[5], m[2] - m[6], m[3] - m[1]};
         1: row = '{m[7] - m[5], trace[1], m[3] + m[1], m[2] + m[6]};
         2: row = '{m[2] - m[6], m[3] + m[1], trace[2], m[5] + m[7]};
         default: row = '{m[3] - m[1], m[6] + m[2], m[7] + m[5], trace[3]};
      endcase
      div = 2 * (root[pick] > rmaa_pkg::ROOT_FLOOR ? root[pick] : rmaa_pkg::ROOT_FLOOR);
      for (int k = 0; k < 4; k++) quat[k] = round_div(row[k] * rmaa_pkg::TRACE_ONE, div);
      norm = int_sqrt(quat[1] * quat[1] + quat[2] * quat[2] + quat[3] * quat[3]);
      if (norm == 0) begin
         res = '{17'sd0, 17'sd0, 17'sd0, 1'b1};
         return res;
      end
      angle = double_angle(norm, quat[0] < 0 ? -quat[0] : quat[0]);
      res.zero = 1'b0;
      v = round_div(angle * quat[1], norm); res.ax = 17'(quat[0] < 0 ? -v : v);
      v = round_div(angle * quat[2], norm); res.ay = 17'(quat[0] < 0 ? -v : v);
      v = round_div(angle * quat[3], norm); res.az = 17'(quat[0] < 0 ? -v : v);
      return res;
   endfunction

   assign pending = expected_vectors.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      longint m[9];
      axis_angle_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         m = '{req_bus.m00, req_bus.m01, req_bus.m02, req_bus.m10, req_bus.m11,
               req_bus.m12, req_bus.m20, req_bus.m21, req_bus.m22};
         expected_vectors.insert(expected_vectors.size(), matrix_to_axis_angle(m));
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_vectors.size() == 0) begin
            $error("unexpected result beat");
            fail_count++;
         end else begin
            want = expected_vectors.pop_front();
            if (rsp_bus.axis_angle_x !== want.ax) begin
               $error("axis_angle_x expected %0d actual %0d", want.ax, rsp_bus.axis_angle_x);
               fail_count++;
            end
            if (rsp_bus.axis_angle_y !== want.ay) begin
               $error("axis_angle_y expected %0d actual %0d", want.ay, rsp_bus.axis_angle_y);
               fail_count++;
            end
            if (rsp_bus.axis_angle_z !== want.az) begin
               $error("axis_angle_z expected %0d actual %0d", want.az, rsp_bus.axis_angle_z);
               fail_count++;
            end
            if (rsp_bus.zero_rotation !== want.zero) begin
               $error("zero_rotation expected %0d actual %0d", want.zero,
                      rsp_bus.zero_rotation);
               fail_count++;
            end
         end
      end
   end

endmodule

FILE: test/rotation_matrix_to_axis_angle_tb.sv
`timescale 1ns / 100ps
module rotation_matrix_to_axis_angle_tb;
   import rmaa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_off = 1'b0;

   rmaa_req_if req_bus ();
   rmaa_rsp_if rsp_bus ();

   rotation_matrix_to_axis_angle dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   rotation_matrix_to_axis_angle_check checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver side
   initial rsp_bus.ready = 1'b0;
   always @(posedge clock)
      rsp_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

   function automatic logic signed [15:0] rand_entry();
      case ($urandom_range(9))
         0:       return 16'sh8000 + 16'($urandom_range(3));
         1:       return 16'sh7fff - 16'($urandom_range(3));
         2:       return 16'sd16384;
         3:       return -16'sd16384;
         4:       return 16'sd0;
         5:       return 16'($urandom);
         default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
      endcase
   endfunction

   // place beat on bus and hold until taken, valid drops only on idle cycles
   task automatic send_matrix(input logic signed [15:0] e[9]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      {req_bus.m00, req_bus.m01, req_bus.m02, req_bus.m10, req_bus.m11, req_bus.m12,
       req_bus.m20, req_bus.m21, req_bus.m22} <= {e[0], e[1], e[2], e[3], e[4], e[5],
                                                  e[6], e[7], e[8]};
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // proper rotation about a random axis, built from real cos/sin values
   task automatic send_rotation();
      logic signed [15:0] e[9];
      real c, s, ang, ux, uy, uz, len, t;
      ang = ($urandom_range(62832) / 10000.0) - 3.1416;
      ux = $urandom_range(2000) - 1000.0;
      uy = $urandom_range(2000) - 1000.0;
      uz = $urandom_range(2000) - 1000.0;
      len = $sqrt(ux * ux + uy * uy + uz * uz);
      if (len < 1.0) begin ux = 1.0; len = 1.0; end
      ux /= len; uy /= len; uz /= len;
      c = $cos(ang); s = $sin(ang); t = 1.0 - c;
      e[0] = 16'($rtoi(16384.0 * (t * ux * ux + c)));
      e[1] = 16'($rtoi(16384.0 * (t * ux * uy - s * uz)));
      e[2] = 16'($rtoi(16384.0 * (t * ux * uz + s * uy)));
      e[3] = 16'($rtoi(16384.0 * (t * ux * uy + s * uz)));
      e[4] = 16'($rtoi(16384.0 * (t * uy * uy + c)));
      e[5] = 16'($rtoi(16384.0 * (t * uy * uz - s * ux)));
      e[6] = 16'($rtoi(16384.0 * (t * ux * uz - s * uy)));
      e[7] = 16'($rtoi(16384.0 * (t * uy * uz + s * ux)));
      e[8] = 16'($rtoi(16384.0 * (t * uz * uz + c)));
      send_matrix(e);
   endtask

   task automatic send_random_item();
      logic signed [15:0] e[9];
      if ($urandom_range(99) < 70) begin
         send_rotation();
      end else begin
         foreach (e[k]) e[k] = rand_entry();
         send_matrix(e);
      end
   endtask

   initial begin
      int idle_base;
      idle_base = 0;
      req_bus.valid = 1'b0;
      {req_bus.m00, req_bus.m01, req_bus.m02, req_bus.m10, req_bus.m11, req_bus.m12,
       req_bus.m20, req_bus.m21, req_bus.m22} = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity: zero rotation flag
      send_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
      // half turns about x, y, z pick rows one to three
      send_matrix('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
      send_matrix('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
      send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
      // quarter turn about z, w positive
      send_matrix('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384});
      // equal positive trace sums in rows one to three, row one picked
      send_matrix('{-16384, 100, -200, 300, -16384, 400, -500, 600, -16384});
      // all zero matrix
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      // ties between rows
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_matrix('{16384, 500, 0, 0, 16384, 0, 0, 0, -16384});
      // quarter turns about x and y, w row wins the tie
      send_matrix('{16384, 0, 0, 0, 0, 16384, 0, -16384, 0});
      send_matrix('{0, 0, -16384, 0, 16384, 0, 16384, 0, 0});
      // zero w with nonzero vector
      send_matrix('{16384, 0, 0, 0, -16384, 100, 0, 100, -16384});
      // full range patterns, every bit both ways
      send_matrix('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
      send_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
      send_matrix('{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767});
      send_matrix('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768});
      send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
      send_matrix('{21845, -21846, 10922, -10923, 21845, -21846, 10922, -10923, 21845});

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_base = 0;  recv_stall_pct = 0;  end
            1: begin idle_base = 83; recv_stall_pct = 0;  end
            2: begin idle_base = 0;  recv_stall_pct = 83; end
            default: begin idle_base = 25; recv_stall_pct = 25; end
         endcase
         for (int i = 0; i < 420; i++) begin
            // long stretches with no idling in between
            send_idle_pct = ((i / 75) % 2 == 1) ? 0 : idle_base;
            send_random_item();
         end
      end

      // receiver held off long enough to fill the pipe and back up the input
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 150; i++) send_random_item();
            req_bus.valid <= 1'b0;
         end
      join

      while (pending != 0) @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: rotation_matrix_to_axis_angle.f
sv/rmaa_pkg.sv
sv/rmaa_if.sv
sv/rmaa_sqrt.sv
sv/rmaa_div.sv
sv/rotation_matrix_to_axis_angle.sv
test/rotation_matrix_to_axis_angle_check.sv
test/rotation_matrix_to_axis_angle_tb.sv
